// ===== rtl/core/rrss_pkg.sv =====
// Shared types, codes and widths of the round-robin slice scheduler.
package rrss_pkg;

  localparam int MAX_PROCS_DEF = 16;

  localparam int MODE_W     = 2;
  localparam int KIND_W     = 2;
  localparam int BURST_W    = 16;
  localparam int TIME_W     = 21;
  localparam int TOTAL_W    = 24;
  localparam int OUT_TIME_W = 20;
  localparam int PNUM_W     = 5;

  localparam logic [BURST_W-1:0] SLICE_RST = 16'd4;

  typedef enum logic [MODE_W-1:0] {
    MODE_CLEAR = 2'd0,
    MODE_LOAD  = 2'd1,
    MODE_STEP  = 2'd2
  } mode_t;

  typedef enum logic [KIND_W-1:0] {
    KIND_OK   = 2'd0,
    KIND_RUN  = 2'd1,
    KIND_DONE = 2'd2,
    KIND_FULL = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_CALC,
    ST_WB,
    ST_OUT
  } state_t;

  // One row of the process table.
  typedef struct packed {
    logic [BURST_W-1:0] burst;
    logic [TIME_W-1:0]  wait_acc;
    logic [TIME_W-1:0]  last_end;
  } entry_t;

  // One result beat.
  typedef struct packed {
    kind_t                 kind;
    logic [PNUM_W-1:0]     pnum;
    logic [OUT_TIME_W-1:0] slice_start;
    logic [OUT_TIME_W-1:0] slice_end;
    logic                  finished;
    logic [OUT_TIME_W-1:0] waiting;
    logic [TOTAL_W-1:0]    total;
  } result_t;

endpackage

// ===== rtl/core/rrss_table.sv =====
// Process table memory: one write port, one read port with registered data.
module rrss_table #(
  parameter int DEPTH = rrss_pkg::MAX_PROCS_DEF,
  parameter int IDX_W = 4
) (
  input  logic                  clk,
  input  logic                  we,
  input  logic [IDX_W-1:0]      waddr,
  input  rrss_pkg::entry_t      wdata,
  input  logic                  re,
  input  logic [IDX_W-1:0]      raddr,
  output rrss_pkg::entry_t      rdata
);

  rrss_pkg::entry_t mem [DEPTH];
  rrss_pkg::entry_t rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/core/rrss_ctrl.sv =====
// Sequencer: decodes items, scans the table, updates the served entry.
module rrss_ctrl #(
  parameter int MAX_PROCS = rrss_pkg::MAX_PROCS_DEF,
  parameter int IDX_W     = 4
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  logic [rrss_pkg::MODE_W-1:0]   in_mode,
  input  logic [rrss_pkg::BURST_W-1:0]  in_burst,
  output logic                          busy,
  input  logic [rrss_pkg::BURST_W-1:0]  time_slice,
  output logic                          mem_we,
  output logic [IDX_W-1:0]              mem_waddr,
  output rrss_pkg::entry_t              mem_wdata,
  output logic                          mem_re,
  output logic [IDX_W-1:0]              mem_raddr,
  input  rrss_pkg::entry_t              mem_rdata,
  output logic                          res_valid,
  output rrss_pkg::result_t             res,
  input  logic                          res_take
);

  localparam int CNT_W = $clog2(MAX_PROCS + 1);
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_PROCS);

  rrss_pkg::state_t                   state_r, state_nxt;
  logic [CNT_W-1:0]                   cnt_r, cnt_nxt;
  logic [IDX_W-1:0]                   scan_r, scan_nxt;
  logic                               prev_vld_r, prev_vld_nxt;
  logic [IDX_W-1:0]                   prev_idx_r, prev_idx_nxt;
  logic [rrss_pkg::TIME_W-1:0]        clock_r, clock_nxt;
  logic [rrss_pkg::TOTAL_W-1:0]       total_r, total_nxt;
  logic [IDX_W-1:0]                   chk_idx_r, chk_idx_nxt;
  logic [CNT_W-1:0]                   chk_left_r, chk_left_nxt;
  rrss_pkg::entry_t                   ent_r, ent_nxt;
  logic [rrss_pkg::BURST_W-1:0]       run_r, run_nxt;
  logic [rrss_pkg::TIME_W-1:0]        inc_r, inc_nxt;
  rrss_pkg::result_t                  res_r, res_nxt;

  logic [CNT_W-1:0]                   cnt_inc;
  logic [CNT_W-1:0]                   idx_inc;
  logic [IDX_W-1:0]                   idx_wrap;
  logic [rrss_pkg::TIME_W-1:0]        clock_sum;
  logic [rrss_pkg::BURST_W-1:0]       burst_left;
  logic                               first_serve;
  logic [rrss_pkg::TIME_W-1:0]        wait_sum;
  logic [rrss_pkg::TOTAL_W-1:0]       total_sum;
  rrss_pkg::result_t                  res_done;

  always_comb begin
    cnt_inc     = cnt_r + CNT_W'(1);
    idx_inc     = CNT_W'(chk_idx_r) + CNT_W'(1);
    idx_wrap    = (idx_inc == cnt_r) ? '0 : IDX_W'(idx_inc);
    clock_sum   = clock_r + rrss_pkg::TIME_W'(run_r);
    burst_left  = ent_r.burst - run_r;
    first_serve = !(prev_vld_r && (prev_idx_r == chk_idx_r));
    wait_sum    = ent_r.wait_acc + inc_r;
    total_sum   = total_r + rrss_pkg::TOTAL_W'(inc_r);

    // nothing left to run: clock shown as both start and end
    res_done             = '0;
    res_done.kind        = rrss_pkg::KIND_DONE;
    res_done.slice_start = clock_r[rrss_pkg::OUT_TIME_W-1:0];
    res_done.slice_end   = clock_r[rrss_pkg::OUT_TIME_W-1:0];
    res_done.total       = total_r;

    state_nxt    = state_r;
    cnt_nxt      = cnt_r;
    scan_nxt     = scan_r;
    prev_vld_nxt = prev_vld_r;
    prev_idx_nxt = prev_idx_r;
    clock_nxt    = clock_r;
    total_nxt    = total_r;
    chk_idx_nxt  = chk_idx_r;
    chk_left_nxt = chk_left_r;
    ent_nxt      = ent_r;
    run_nxt      = run_r;
    inc_nxt      = inc_r;
    res_nxt      = res_r;

    mem_we             = 1'b0;
    mem_waddr          = IDX_W'(cnt_r);
    mem_wdata.burst    = in_burst;
    mem_wdata.wait_acc = '0;
    mem_wdata.last_end = '0;
    mem_re             = 1'b0;
    mem_raddr          = scan_r;

    unique case (state_r)
      rrss_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_nxt = rrss_pkg::ST_OUT;
          unique case (rrss_pkg::mode_t'(in_mode))
            rrss_pkg::MODE_CLEAR: begin
              cnt_nxt      = '0;
              scan_nxt     = '0;
              prev_vld_nxt = 1'b0;
              clock_nxt    = '0;
              total_nxt    = '0;
              res_nxt      = '0;
            end
            rrss_pkg::MODE_LOAD: begin
              res_nxt       = '0;
              res_nxt.total = total_r;
              if (cnt_r == CNT_MAX) begin
                res_nxt.kind = rrss_pkg::KIND_FULL;
              end else begin
                mem_we       = 1'b1;
                cnt_nxt      = cnt_inc;
                res_nxt.kind = rrss_pkg::KIND_OK;
                res_nxt.pnum = rrss_pkg::PNUM_W'(cnt_inc);
              end
            end
            rrss_pkg::MODE_STEP: begin
              if (cnt_r == '0) begin
                res_nxt = res_done;
              end else begin
                mem_re       = 1'b1;
                mem_raddr    = scan_r;
                chk_idx_nxt  = scan_r;
                chk_left_nxt = cnt_r;
                state_nxt    = rrss_pkg::ST_SCAN;
              end
            end
            default: begin
              res_nxt = res_done;
            end
          endcase
        end
      end
      rrss_pkg::ST_SCAN: begin
        // one entry checked per cycle; next read goes out as soon as this one is empty
        if (mem_rdata.burst != '0) begin
          ent_nxt   = mem_rdata;
          state_nxt = rrss_pkg::ST_CALC;
        end else if (chk_left_r == CNT_W'(1)) begin
          res_nxt   = res_done;
          state_nxt = rrss_pkg::ST_OUT;
        end else begin
          chk_idx_nxt  = idx_wrap;
          chk_left_nxt = chk_left_r - CNT_W'(1);
          mem_re       = 1'b1;
          mem_raddr    = idx_wrap;
        end
      end
      rrss_pkg::ST_CALC: begin
        run_nxt   = (ent_r.burst < time_slice) ? ent_r.burst : time_slice;
        // end - last_end - run equals start - last_end
        inc_nxt   = clock_r - ent_r.last_end;
        state_nxt = rrss_pkg::ST_WB;
      end
      rrss_pkg::ST_WB: begin
        mem_we             = 1'b1;
        mem_waddr          = chk_idx_r;
        mem_wdata.burst    = burst_left;
        mem_wdata.wait_acc = first_serve ? wait_sum : ent_r.wait_acc;
        mem_wdata.last_end = first_serve ? clock_sum : ent_r.last_end;
        if (first_serve) begin
          total_nxt = total_sum;
        end
        prev_vld_nxt = 1'b1;
        prev_idx_nxt = chk_idx_r;
        clock_nxt    = clock_sum;
        scan_nxt     = idx_wrap;

        res_nxt.kind        = rrss_pkg::KIND_RUN;
        res_nxt.pnum        = rrss_pkg::PNUM_W'(idx_inc);
        res_nxt.slice_start = clock_r[rrss_pkg::OUT_TIME_W-1:0];
        res_nxt.slice_end   = clock_sum[rrss_pkg::OUT_TIME_W-1:0];
        res_nxt.finished    = (burst_left == '0);
        res_nxt.waiting     = first_serve ? wait_sum[rrss_pkg::OUT_TIME_W-1:0]
                                          : ent_r.wait_acc[rrss_pkg::OUT_TIME_W-1:0];
        res_nxt.total       = first_serve ? total_sum : total_r;
        state_nxt           = rrss_pkg::ST_OUT;
      end
      rrss_pkg::ST_OUT: begin
        if (res_take) begin
          state_nxt = rrss_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = rrss_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= rrss_pkg::ST_IDLE;
      cnt_r      <= '0;
      scan_r     <= '0;
      prev_vld_r <= 1'b0;
      prev_idx_r <= '0;
      clock_r    <= '0;
      total_r    <= '0;
    end else begin
      state_r    <= state_nxt;
      cnt_r      <= cnt_nxt;
      scan_r     <= scan_nxt;
      prev_vld_r <= prev_vld_nxt;
      prev_idx_r <= prev_idx_nxt;
      clock_r    <= clock_nxt;
      total_r    <= total_nxt;
    end
  end

  always_ff @(posedge clk) begin
    chk_idx_r  <= chk_idx_nxt;
    chk_left_r <= chk_left_nxt;
    ent_r      <= ent_nxt;
    run_r      <= run_nxt;
    inc_r      <= inc_nxt;
    res_r      <= res_nxt;
  end

  assign busy      = (state_r != rrss_pkg::ST_IDLE);
  assign res_valid = (state_r == rrss_pkg::ST_OUT);
  assign res       = res_r;

endmodule

// ===== rtl/core/round_robin_slice_scheduler_unit.sv =====
// Top level of the round-robin slice scheduler: config register, output stage, sequencer.
//
// Usage: each input beat (in_valid/in_stall) carries a mode: clear the table, load one
// process burst, or run the next time slice. Every input beat yields exactly one result
// beat on out_valid/out_stall. cfg_we writes time_slice at any edge while the block is
// idle; it holds until rewritten.
// Clear, load and the unused mode go from idle to the output state. A step
// examines from one up to the process count of table entries (at most MAX_PROCS); if it
// serves a process, ST_CALC then computes the run length and ST_WB writes back. A step
// on an empty table reports done without a scan. The scan reads one memory entry per
// cycle through the table's single read port.
// Items are handled one at a time; in_stall stays high from acceptance until the
// result moves into the output register.
// The output register frees the sequencer: a new item is taken while the previous
// result still waits on a stalled receiver. Out payload holds while out_stall is high.
// Reset (rst_n low, synchronous) empties the table, zeros the clock and the total wait,
// sets time_slice to 4 and drops any pending result. The table memory is not cleared:
// a load writes each row before it can be read.
module round_robin_slice_scheduler_unit #(
  parameter int MAX_PROCS = rrss_pkg::MAX_PROCS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [rrss_pkg::MODE_W-1:0]       in_mode,
  input  logic [rrss_pkg::BURST_W-1:0]      in_burst_time,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [rrss_pkg::KIND_W-1:0]       out_kind,
  output logic [rrss_pkg::PNUM_W-1:0]       out_process_number,
  output logic [rrss_pkg::OUT_TIME_W-1:0]   out_slice_start,
  output logic [rrss_pkg::OUT_TIME_W-1:0]   out_slice_end,
  output logic                              out_finished,
  output logic [rrss_pkg::OUT_TIME_W-1:0]   out_waiting_time,
  output logic [rrss_pkg::TOTAL_W-1:0]      out_total_waiting,
  input  logic                              cfg_we,
  input  logic [rrss_pkg::BURST_W-1:0]      cfg_wdata
);

  localparam int IDX_W = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;

  logic [rrss_pkg::BURST_W-1:0] slice_r, slice_nxt;
  logic                         out_vld_r, out_vld_nxt;
  rrss_pkg::result_t            out_res_r, out_res_nxt;

  logic                         busy;
  logic                         mem_we;
  logic [IDX_W-1:0]             mem_waddr;
  rrss_pkg::entry_t             mem_wdata;
  logic                         mem_re;
  logic [IDX_W-1:0]             mem_raddr;
  rrss_pkg::entry_t             mem_rdata;
  logic                         res_valid;
  rrss_pkg::result_t            res;
  logic                         res_take;

  rrss_table #(
    .DEPTH (MAX_PROCS),
    .IDX_W (IDX_W)
  ) u_table (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  rrss_ctrl #(
    .MAX_PROCS (MAX_PROCS),
    .IDX_W     (IDX_W)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_mode    (in_mode),
    .in_burst   (in_burst_time),
    .busy       (busy),
    .time_slice (slice_r),
    .mem_we     (mem_we),
    .mem_waddr  (mem_waddr),
    .mem_wdata  (mem_wdata),
    .mem_re     (mem_re),
    .mem_raddr  (mem_raddr),
    .mem_rdata  (mem_rdata),
    .res_valid  (res_valid),
    .res        (res),
    .res_take   (res_take)
  );

  // The output register takes a new result when empty or when its beat leaves now.
  assign res_take = !out_vld_r || !out_stall;

  always_comb begin
    slice_nxt   = cfg_we ? cfg_wdata : slice_r;
    out_vld_nxt = out_vld_r;
    out_res_nxt = out_res_r;
    if (res_take) begin
      out_vld_nxt = res_valid;
      if (res_valid) begin
        out_res_nxt = res;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slice_r   <= rrss_pkg::SLICE_RST;
      out_vld_r <= 1'b0;
    end else begin
      slice_r   <= slice_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  // payload only; qualified by out_vld_r
  always_ff @(posedge clk) begin
    out_res_r <= out_res_nxt;
  end

  assign in_stall           = busy;
  assign out_valid          = out_vld_r;
  assign out_kind           = out_res_r.kind;
  assign out_process_number = out_res_r.pnum;
  assign out_slice_start    = out_res_r.slice_start;
  assign out_slice_end      = out_res_r.slice_end;
  assign out_finished       = out_res_r.finished;
  assign out_waiting_time   = out_res_r.waiting;
  assign out_total_waiting  = out_res_r.total;

  // An accepted item always occupies the sequencer for at least the next cycle.
  a_accept_then_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("sequencer free right after accepting an item");

  // No new item while a finished result waits inside the sequencer.
  a_pending_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid |-> in_stall)
    else $error("input open while a result is pending");

  // A done report shows the current clock as both start and end and no finish.
  a_done_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_kind == rrss_pkg::KIND_DONE) |->
      (out_slice_start == out_slice_end) && !out_finished)
    else $error("inconsistent done result");

  // A served slice names a process whenever MAX_PROCS is below 32.
  a_run_has_process: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_kind == rrss_pkg::KIND_RUN) && (MAX_PROCS < 32) |->
      (out_process_number != '0))
    else $error("slice result without a process number");

endmodule

// ===== verif/tb_top.sv =====
// Self-checking testbench for the round-robin slice scheduler unit.
`timescale 1ns / 100ps

module tb_top;

  localparam int MODE_W     = rrss_pkg::MODE_W;
  localparam int KIND_W     = rrss_pkg::KIND_W;
  localparam int BURST_W    = rrss_pkg::BURST_W;
  localparam int TIME_W     = rrss_pkg::TIME_W;
  localparam int TOTAL_W    = rrss_pkg::TOTAL_W;
  localparam int OUT_TIME_W = rrss_pkg::OUT_TIME_W;
  localparam int PNUM_W     = rrss_pkg::PNUM_W;

  localparam int                TBL_DEPTH  = rrss_pkg::MAX_PROCS_DEF;
  // Mode code the block leaves unused; it must report like an empty step.
  localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;
  localparam int                NO_PREV    = -1;
  localparam int                MAX_GAP    = 19;

  // One input beat waiting to be driven, with the idle cycles that follow it.
  typedef struct {
    logic [MODE_W-1:0]  mode;
    logic [BURST_W-1:0] burst;
    int                 gap;
  } job_t;

  logic                  clk           = 1'b0;
  logic                  rst_n         = 1'b0;
  logic                  in_valid      = 1'b0;
  logic                  in_stall;
  logic [MODE_W-1:0]     in_mode       = '0;
  logic [BURST_W-1:0]    in_burst_time = '0;
  logic                  out_valid;
  logic                  out_stall     = 1'b0;
  logic [KIND_W-1:0]     out_kind;
  logic [PNUM_W-1:0]     out_process_number;
  logic [OUT_TIME_W-1:0] out_slice_start;
  logic [OUT_TIME_W-1:0] out_slice_end;
  logic                  out_finished;
  logic [OUT_TIME_W-1:0] out_waiting_time;
  logic [TOTAL_W-1:0]    out_total_waiting;
  logic                  cfg_we        = 1'b0;
  logic [BURST_W-1:0]    cfg_wdata     = '0;

  job_t              job_queue[$];     // beats not yet offered to the block
  rrss_pkg::result_t report_queue[$];  // predicted result beats, oldest first
  job_t              next_job;
  rrss_pkg::result_t want;
  int                fail_count = 0;
  int                job_total  = 0;   // beats queued, the unused mode not counted
  int                gap_left   = 0;
  int                hold_left  = 0;
  bit                calm_in    = 1'b0;
  bit                calm_out   = 1'b0;

  // Scheduler mirror: process table, circular pointer, clock and wait totals.
  logic [BURST_W-1:0] tbl_burst    [TBL_DEPTH];
  logic [TIME_W-1:0]  tbl_wait     [TBL_DEPTH];
  logic [TIME_W-1:0]  tbl_last_end [TBL_DEPTH];
  int                 tbl_count;
  int                 rr_pos;
  int                 rr_prev;
  logic [TIME_W-1:0]  sched_clock;
  logic [TOTAL_W-1:0] wait_total;
  logic [BURST_W-1:0] quantum;

  round_robin_slice_scheduler_unit DUT (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_mode            (in_mode),
    .in_burst_time      (in_burst_time),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_kind           (out_kind),
    .out_process_number (out_process_number),
    .out_slice_start    (out_slice_start),
    .out_slice_end      (out_slice_end),
    .out_finished       (out_finished),
    .out_waiting_time   (out_waiting_time),
    .out_total_waiting  (out_total_waiting),
    .cfg_we             (cfg_we),
    .cfg_wdata          (cfg_wdata)
  );

  always #10 clk = ~clk;

  // Empty the table and zero the clock, as a clear beat or reset does.
  function automatic void wipe_table();
    for (int p = 0; p < TBL_DEPTH; p++) begin
      tbl_burst[p]    = '0;
      tbl_wait[p]     = '0;
      tbl_last_end[p] = '0;
    end
    tbl_count   = 0;
    rr_pos      = 0;
    rr_prev     = NO_PREV;
    sched_clock = '0;
    wait_total  = '0;
  endfunction

  // Apply one accepted beat to the mirror and return the result it causes.
  function automatic rrss_pkg::result_t serve_job(logic [MODE_W-1:0] mode,
                                                  logic [BURST_W-1:0] burst);
    rrss_pkg::result_t  r;
    int                 idx;
    logic [BURST_W-1:0] run;
    logic [TIME_W-1:0]  start;
    logic [TIME_W-1:0]  inc;
    r = '0;
    if (mode == rrss_pkg::MODE_CLEAR) begin
      wipe_table();
      return r;
    end
    r.total = wait_total;
    if (mode == rrss_pkg::MODE_LOAD) begin
      if (tbl_count >= TBL_DEPTH) begin
        r.kind = rrss_pkg::KIND_FULL;
        return r;
      end
      // A late arrival starts from time zero, so its first wait counts from there.
      tbl_burst[tbl_count]    = burst;
      tbl_wait[tbl_count]     = '0;
      tbl_last_end[tbl_count] = '0;
      tbl_count++;
      r.pnum = PNUM_W'(tbl_count);
      return r;
    end
    r.kind        = rrss_pkg::KIND_DONE;
    r.slice_start = sched_clock[OUT_TIME_W-1:0];
    r.slice_end   = sched_clock[OUT_TIME_W-1:0];
    if (mode != rrss_pkg::MODE_STEP || tbl_count == 0)
      return r;
    for (int k = 0; k < tbl_count; k++) begin
      idx = (rr_pos + k) % tbl_count;
      if (tbl_burst[idx] == 0)
        continue;
      run            = (tbl_burst[idx] < quantum) ? tbl_burst[idx] : quantum;
      start          = sched_clock;
      sched_clock    = sched_clock + TIME_W'(run);
      tbl_burst[idx] = tbl_burst[idx] - run;
      // Charge waiting only on a switch to another process.
      if (rr_prev != idx) begin
        inc               = sched_clock - tbl_last_end[idx] - TIME_W'(run);
        rr_prev           = idx;
        tbl_wait[idx]     = tbl_wait[idx] + inc;
        tbl_last_end[idx] = sched_clock;
        wait_total        = wait_total + TOTAL_W'(inc);
      end
      rr_pos        = (idx + 1) % tbl_count;
      r.kind        = rrss_pkg::KIND_RUN;
      r.pnum        = PNUM_W'(idx + 1);
      r.slice_start = start[OUT_TIME_W-1:0];
      r.slice_end   = sched_clock[OUT_TIME_W-1:0];
      r.finished    = (tbl_burst[idx] == 0);
      r.waiting     = tbl_wait[idx][OUT_TIME_W-1:0];
      r.total       = wait_total;
      return r;
    end
    return r;
  endfunction

  // Input driver: predict on every accepted beat, hold while stalled, then
  // idle for the gap drawn with the beat before offering the next one.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      gap_left = 0;
      wipe_table();
      quantum = rrss_pkg::SLICE_RST;
    end else begin
      if (in_valid && !in_stall)
        report_queue.push_back(serve_job(in_mode, in_burst_time));
      if (!(in_valid && in_stall)) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (job_queue.size() > 0) begin
          next_job = job_queue.pop_front();
          in_valid      <= 1'b1;
          in_mode       <= next_job.mode;
          in_burst_time <= next_job.burst;
          gap_left = next_job.gap;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor: check each accepted beat against the oldest prediction,
  // then stall for a freshly drawn number of cycles.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      hold_left = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (report_queue.size() == 0) begin
          $error("result beat with no prediction pending: kind %0d", out_kind);
          fail_count++;
        end else begin
          want = report_queue.pop_front();
          if (out_kind !== want.kind) begin
            $error("kind: expected %0d, actual %0d", want.kind, out_kind);
            fail_count++;
          end
          if (out_process_number !== want.pnum) begin
            $error("process_number: expected %0d, actual %0d", want.pnum,
                   out_process_number);
            fail_count++;
          end
          if (out_slice_start !== want.slice_start) begin
            $error("slice_start: expected %0d, actual %0d", want.slice_start,
                   out_slice_start);
            fail_count++;
          end
          if (out_slice_end !== want.slice_end) begin
            $error("slice_end: expected %0d, actual %0d", want.slice_end, out_slice_end);
            fail_count++;
          end
          if (out_finished !== want.finished) begin
            $error("finished: expected %0d, actual %0d", want.finished, out_finished);
            fail_count++;
          end
          if (out_waiting_time !== want.waiting) begin
            $error("waiting_time: expected %0d, actual %0d", want.waiting,
                   out_waiting_time);
            fail_count++;
          end
          if (out_total_waiting !== want.total) begin
            $error("total_waiting: expected %0d, actual %0d", want.total,
                   out_total_waiting);
            fail_count++;
          end
        end
        hold_left = calm_out ? 0 : $urandom_range(0, MAX_GAP);
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  task automatic push_job(logic [MODE_W-1:0] mode, logic [BURST_W-1:0] burst);
    job_t j;
    j.mode  = mode;
    j.burst = burst;
    j.gap   = calm_in ? 0 : $urandom_range(0, MAX_GAP);
    job_queue.push_back(j);
    if (mode != MODE_SPARE)
      job_total++;
  endtask

  // Wait until every beat is driven and every result has come back.
  task automatic settle();
    while (!(job_queue.size() == 0 && !in_valid && report_queue.size() == 0))
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Write the slice length while the block is idle and mirror it.
  task automatic set_quantum(logic [BURST_W-1:0] value);
    settle();
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    quantum = value;
  endtask

  // Bursts scale with the slice so that most sequences run to completion.
  function automatic int draw_burst();
    int q;
    int cap;
    int pick;
    q    = int'(quantum);
    cap  = (q == 0) ? 8 : ((3 * q + 3 > 65535) ? 65535 : 3 * q + 3);
    pick = $urandom_range(0, 9);
    if (pick == 0)
      return 0;
    if (pick == 1 && q >= 4096)
      return 65535;
    return $urandom_range(1, cap);
  endfunction

  function automatic int slices_for(int burst);
    int q;
    q = int'(quantum);
    return (q == 0) ? 4 : (burst + q - 1) / q;
  endfunction

  // One workload: clear, load a batch, then step it through. Some batches
  // overfill the table, some are cut short, some get late arrivals.
  task automatic run_sequence();
    int nproc;
    int need;
    int steps;
    int b;
    bit broken;
    calm_in  = ($urandom_range(0, 3) == 0);
    calm_out = ($urandom_range(0, 3) == 0);
    broken   = ($urandom_range(0, 7) == 0);
    push_job(rrss_pkg::MODE_CLEAR, BURST_W'($urandom));
    nproc = $urandom_range(1, TBL_DEPTH);
    need  = 0;
    for (int p = 0; p < nproc; p++) begin
      b = draw_burst();
      need += slices_for(b);
      push_job(rrss_pkg::MODE_LOAD, BURST_W'(b));
    end
    if ($urandom_range(0, 5) == 0)
      for (int p = 0; p < $urandom_range(1, 4); p++)
        push_job(rrss_pkg::MODE_LOAD, BURST_W'(draw_burst()));
    steps = broken ? need / 2 : need + $urandom_range(0, 3);
    if (steps > 300)
      steps = 300;
    for (int s = 0; s < steps; s++) begin
      if ($urandom_range(0, 30) == 0)
        push_job(rrss_pkg::MODE_LOAD, BURST_W'(draw_burst()));
      push_job(rrss_pkg::MODE_STEP, BURST_W'($urandom));
    end
  endtask

  // A few beats of arbitrary mode and payload, the unused mode included.
  task automatic add_noise();
    calm_in = ($urandom_range(0, 1) == 0);
    for (int n = 0; n < $urandom_range(1, 6); n++)
      push_job(MODE_W'($urandom_range(0, 3)), BURST_W'($urandom));
  endtask

  initial begin
    logic [BURST_W-1:0] q;
    int                 goal;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: empty table, unused mode, extreme bursts, late loads,
    // a full table and a clear, all at the reset slice length.
    push_job(rrss_pkg::MODE_STEP, 16'h0000);
    push_job(MODE_SPARE, 16'hFFFF);
    push_job(rrss_pkg::MODE_LOAD, 16'hFFFF);
    push_job(rrss_pkg::MODE_LOAD, 16'h0000);
    push_job(rrss_pkg::MODE_LOAD, 16'h0001);
    push_job(rrss_pkg::MODE_LOAD, 16'h0007);
    repeat (3) push_job(rrss_pkg::MODE_STEP, 16'h0000);
    repeat (12) push_job(rrss_pkg::MODE_LOAD, BURST_W'(draw_burst()));
    push_job(rrss_pkg::MODE_LOAD, 16'h1234);
    repeat (2) push_job(rrss_pkg::MODE_STEP, 16'hFFFF);
    push_job(rrss_pkg::MODE_CLEAR, 16'hFFFF);

    // Directed: a zero slice never advances the clock, then the widest slice.
    set_quantum(16'h0000);
    push_job(rrss_pkg::MODE_LOAD, 16'd9);
    repeat (2) push_job(rrss_pkg::MODE_STEP, 16'h0000);
    set_quantum(16'hFFFF);
    repeat (2) push_job(rrss_pkg::MODE_STEP, 16'h0000);
    push_job(rrss_pkg::MODE_CLEAR, 16'h0000);

    // Random phases, each at its own slice length.
    for (int ph = 0; ph < 10; ph++) begin
      case (ph)
        0:       q = 16'd1;
        1:       q = 16'hFFFF;
        2:       q = 16'd2;
        3:       q = BURST_W'($urandom_range(3, 16));
        4:       q = BURST_W'($urandom_range(17, 1000));
        5:       q = BURST_W'($urandom_range(1, 65535));
        6:       q = 16'd1;
        7:       q = 16'hFFFF;
        8:       q = BURST_W'($urandom_range(3, 16));
        default: q = rrss_pkg::SLICE_RST;
      endcase
      set_quantum(q);
      goal = job_total + 108;
      while (job_total < goal) begin
        if ($urandom_range(0, 9) == 0)
          add_noise();
        else
          run_sequence();
        // Keep the pending list short so the stimulus tracks the block.
        while (job_queue.size() > 64)
          @(posedge clk);
      end
    end

    settle();
    repeat (40) @(posedge clk);
    if (fail_count == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

  // Watchdog well beyond the slowest legal run.
  initial begin
    #20_000_000;
    $display("status: fail");
    $finish;
  end

endmodule
